// ===== hw/rtl/mbp_pkg.sv =====
// Package: constants, codes and types shared by the MSB-first bit packer.
package mbp_pkg;

	localparam logic [5:0]  WORD_BITS      = 6'd32;
	localparam int          LEN_W          = 5;
	localparam int          CODE_W         = 31;
	localparam int          FREE_W         = 6;
	localparam int          BYTES_W        = 21;
	localparam int          TOTAL_W        = 24;
	localparam int          NBYTES_W       = 3;
	localparam logic [20:0] BUF_BYTES_RST  = 21'd4096;
	localparam logic [2:0]  WORD_NBYTES    = 3'd4;
	localparam logic        ACT_FLUSH      = 1'b1;
	localparam int          IN_TDATA_W     = 40;
	localparam int          OUT_TDATA_W    = 64;

	typedef enum logic [1:0] {
		STATUS_OK   = 2'd0,
		STATUS_WIDE = 2'd1,
		STATUS_FULL = 2'd2
	} status_t;

endpackage

// ===== hw/rtl/msb_first_bit_packer.sv =====
// MSB-first variable-length bit packer with 32-bit big-endian word output.
// An input beat passes the input register, then the result register, before its result beat.
// Throughput: one beat per cycle unless stalled; the shift and merge are combinational.
// Output stalls back-pressure the input stage only while both registers are full.
// Reset (arst_n low, asynchronous): accumulator empty, byte count zero, capacity 4096 bytes.
module msb_first_bit_packer (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [20:0] cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // code_length[4:0], code_bits[35:5], zero pad
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata,  // out_word[31:0], valid_bytes[34:32], total_bits[58:35]
	output logic [1:0]  m_axis_tuser   // status
);

	logic                           valid_s1;
	logic                           action_s1;
	logic [mbp_pkg::LEN_W-1:0]      code_len_s1;
	logic [mbp_pkg::CODE_W-1:0]     code_bits_s1;

	logic                           out_valid_q;
	logic [31:0]                    out_word_q;
	logic [mbp_pkg::NBYTES_W-1:0]   out_nbytes_q;
	mbp_pkg::status_t               out_status_q;
	logic [mbp_pkg::TOTAL_W-1:0]    out_total_q;

	logic [20:0]                    buf_bytes_q;
	logic [31:0]                    acc_q;
	logic [mbp_pkg::FREE_W-1:0]     free_q;
	logic [mbp_pkg::BYTES_W-1:0]    bytes_q;

	logic [31:0]                    acc_d;
	logic [mbp_pkg::FREE_W-1:0]     free_d;
	logic [mbp_pkg::BYTES_W-1:0]    bytes_d;
	logic [31:0]                    word_d;
	logic [mbp_pkg::NBYTES_W-1:0]   nbytes_d;
	mbp_pkg::status_t               status_d;
	logic [mbp_pkg::TOTAL_W-1:0]    total_d;
	logic                           advance;

	assign advance       = !out_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			action_s1    <= s_axis_tuser;
			code_len_s1  <= s_axis_tdata[4:0];
			code_bits_s1 <= s_axis_tdata[35:5];
		end
	end

	// flush, width and capacity checks, shift and merge for the beat held in the input register
	always_comb begin
		acc_d    = acc_q;
		free_d   = free_q;
		bytes_d  = bytes_q;
		word_d   = '0;
		nbytes_d = '0;
		status_d = mbp_pkg::STATUS_OK;
		if (action_s1 == mbp_pkg::ACT_FLUSH) begin
			if (free_q < mbp_pkg::WORD_BITS) begin
				word_d   = acc_q << free_q[4:0];
				nbytes_d = mbp_pkg::NBYTES_W'((7'(mbp_pkg::WORD_BITS) - 7'(free_q) + 7'd7) >> 3);
				bytes_d  = bytes_q + mbp_pkg::BYTES_W'(nbytes_d);
			end
			acc_d  = '0;
			free_d = mbp_pkg::WORD_BITS;
		end else if ((code_bits_s1 >> code_len_s1) != '0) begin
			status_d = mbp_pkg::STATUS_WIDE;
		end else if ({1'b0, code_len_s1} < free_q) begin
			acc_d  = (acc_q << code_len_s1) | {1'b0, code_bits_s1};
			free_d = free_q - {1'b0, code_len_s1};
		end else if ({1'b0, buf_bytes_q} <= ({1'b0, bytes_q} + 22'd3)) begin
			status_d = mbp_pkg::STATUS_FULL;
		end else begin
			word_d   = (acc_q << free_q[4:0])
				| ({1'b0, code_bits_s1} >> (code_len_s1 - free_q[4:0]));
			nbytes_d = mbp_pkg::WORD_NBYTES;
			bytes_d  = bytes_q + mbp_pkg::BYTES_W'(mbp_pkg::WORD_NBYTES);
			free_d   = free_q + mbp_pkg::WORD_BITS - {1'b0, code_len_s1};
			acc_d    = {1'b0, code_bits_s1};
		end
		total_d = {bytes_d, 3'b000}
			+ mbp_pkg::TOTAL_W'(7'(mbp_pkg::WORD_BITS) - 7'(free_d));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_bytes_q <= mbp_pkg::BUF_BYTES_RST;
			acc_q       <= '0;
			free_q      <= mbp_pkg::WORD_BITS;
			bytes_q     <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				buf_bytes_q <= cfg_wdata;
			end
			if (advance) begin
				out_valid_q <= valid_s1;
				if (valid_s1) begin
					acc_q   <= acc_d;
					free_q  <= free_d;
					bytes_q <= bytes_d;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			out_word_q   <= word_d;
			out_nbytes_q <= nbytes_d;
			out_status_q <= status_d;
			out_total_q  <= total_d;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, out_total_q, out_nbytes_q, out_word_q};
	assign m_axis_tuser  = out_status_q;

`ifndef SYNTHESIS
	a_free_range: assert property (@(posedge clk) disable iff (!arst_n)
		free_q != '0 && free_q <= mbp_pkg::WORD_BITS)
		else $error("free bit count out of range");

	a_err_no_bytes: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_status_q != mbp_pkg::STATUS_OK |-> out_nbytes_q == '0 && out_word_q == '0)
		else $error("error result carries data");

	a_nbytes_max: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> out_nbytes_q <= mbp_pkg::WORD_NBYTES)
		else $error("byte count above word size");

	a_state_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(advance && valid_s1) |=> $stable(bytes_q) && $stable(free_q))
		else $error("packer state changed without a beat");
`endif

endmodule

// ===== verif/tb.sv =====
// Testbench for msb_first_bit_packer: directed and random code streams checked beat by beat.
`timescale 1ns / 100ps

module tb;

	localparam logic ACT_APPEND = 1'b0;
	localparam logic [20:0] CAP_MAX = 21'd1048576;

	typedef struct packed {
		logic [31:0]      word;
		logic [2:0]       nbytes;
		mbp_pkg::status_t status;
		logic [23:0]      total;
	} pack_res_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [20:0] cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;   // code_length[4:0], code_bits[35:5], zero pad
	logic        s_axis_tuser = 1'b0; // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [63:0] m_axis_tdata;        // out_word[31:0], valid_bytes[34:32], total_bits[58:35]
	logic [1:0]  m_axis_tuser;        // status

	msb_first_bit_packer dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser)
	);

	// packer model state
	logic [31:0] acc_bits;
	int unsigned free_slots;
	logic [20:0] bytes_out;
	logic [20:0] capacity;

	pack_res_t due_results[$];
	int errors = 0;
	int n_beats = 0, n_words = 0, n_flushes = 0, n_wide = 0, n_full = 0;
	int n_cap_writes = 0;
	int burst_left = 0;
	bit steady = 1'b0;
	int rx_mode = 0, rx_left = 1, rx_cnt = 0;

	initial forever #5 clk = ~clk;

	initial begin
		#30_000_000;
		$display("FAIL msb_first_bit_packer");
		$finish;
	end

	function automatic pack_res_t pack_predict(input logic act, input logic [4:0] len,
			input logic [30:0] bits);
		pack_res_t r;
		int unsigned n;
		logic [31:0] v;
		n = len;
		v = {1'b0, bits};
		r.word = '0;
		r.nbytes = '0;
		r.status = mbp_pkg::STATUS_OK;
		if (act == mbp_pkg::ACT_FLUSH) begin
			if (free_slots < 32) begin
				r.word = acc_bits << free_slots;
				r.nbytes = 3'((32 - free_slots + 7) >> 3);
				bytes_out = bytes_out + 21'(r.nbytes);
			end
			acc_bits = '0;
			free_slots = 32;
		end else if ((v >> n) != 0) begin
			r.status = mbp_pkg::STATUS_WIDE;
		end else if (n < free_slots) begin
			acc_bits = (acc_bits << n) | v;
			free_slots = free_slots - n;
		end else if (32'(capacity) <= 32'(bytes_out) + 3) begin
			r.status = mbp_pkg::STATUS_FULL;
		end else begin
			r.word = (acc_bits << free_slots) | (v >> (n - free_slots));
			r.nbytes = mbp_pkg::WORD_NBYTES;
			bytes_out = bytes_out + 21'd4;
			free_slots = free_slots + 32 - n;
			acc_bits = v;
		end
		r.total = 24'({bytes_out, 3'b000} + 24'(32 - free_slots));
		return r;
	endfunction

	function automatic logic [30:0] rand_code(input int unsigned len);
		logic [30:0] mask;
		int sel;
		mask = 31'((64'd1 << len) - 1);
		sel = $urandom_range(0, 19);
		if (sel < 2)
			return mask;
		else if (sel == 2)
			return '0;
		return 31'($urandom) & mask;
	endfunction

	task automatic send_item(input logic act, input logic [4:0] len, input logic [30:0] bits);
		int gap;
		pack_res_t r;
		if (!steady && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap > 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0)
			burst_left--;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {4'b0000, bits, len};
		do @(posedge clk); while (!s_axis_tready);
		r = pack_predict(act, len, bits);
		due_results.push_back(r);
		n_beats++;
		if (r.status == mbp_pkg::STATUS_WIDE)
			n_wide++;
		else if (r.status == mbp_pkg::STATUS_FULL)
			n_full++;
		else if (act == mbp_pkg::ACT_FLUSH && r.nbytes != 0)
			n_flushes++;
		else if (r.nbytes == mbp_pkg::WORD_NBYTES)
			n_words++;
		@(negedge clk);
	endtask

	task automatic wait_idle;
		s_axis_tvalid <= 1'b0;
		while (due_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task automatic write_capacity(input logic [20:0] value);
		wait_idle();
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
		capacity = value;
		n_cap_writes++;
	endtask

	task automatic send_random;
		int sel;
		int unsigned len;
		logic [30:0] bits;
		sel = $urandom_range(0, 99);
		if (sel < 8) begin
			send_item(mbp_pkg::ACT_FLUSH, 5'($urandom), 31'($urandom));
		end else if (sel < 14) begin
			len = $urandom_range(0, 30);
			bits = 31'($urandom) | (31'd1 << $urandom_range(len, 30));
			send_item(ACT_APPEND, 5'(len), bits);
		end else begin
			sel = $urandom_range(0, 9);
			len = (sel < 2) ? 31 : (sel == 2) ? 0 : $urandom_range(1, 30);
			send_item(ACT_APPEND, 5'(len), rand_code(len));
		end
	endtask

	task automatic test_directed;
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		send_item(ACT_APPEND, 5'd0, 31'd0);
		send_item(ACT_APPEND, 5'd0, 31'd1);
		send_item(ACT_APPEND, 5'd5, 31'd32);
		send_item(ACT_APPEND, 5'd30, 31'h7FFF_FFFF);
		send_item(ACT_APPEND, 5'd31, 31'h7FFF_FFFF);
		send_item(ACT_APPEND, 5'd1, 31'd1);
		send_item(ACT_APPEND, 5'd1, 31'd1);
		send_item(mbp_pkg::ACT_FLUSH, 5'd31, 31'h7FFF_FFFF);
		send_item(ACT_APPEND, 5'd8, 31'hA5);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		send_item(ACT_APPEND, 5'd9, 31'h1A5);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		send_item(ACT_APPEND, 5'd24, 31'hC3_5A_F0);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		send_item(ACT_APPEND, 5'd25, 31'h1_5A_5A_5A);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		send_item(ACT_APPEND, 5'd31, 31'd0);
		send_item(ACT_APPEND, 5'd31, 31'h5555_5555);
		send_item(ACT_APPEND, 5'd30, 31'h2AAA_AAAA);
		send_item(ACT_APPEND, 5'd3, 31'd5);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
	endtask

	task automatic test_capacity;
		write_capacity(21'd0);
		send_item(ACT_APPEND, 5'd31, 31'h1234_5678);
		send_item(ACT_APPEND, 5'd31, 31'h0765_4321);
		send_item(ACT_APPEND, 5'd1, 31'd1);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		// room for exactly one word
		write_capacity(bytes_out + 21'd4);
		send_item(ACT_APPEND, 5'd20, 31'hF_0F0F);
		send_item(ACT_APPEND, 5'd20, 31'hA_5A5A);
		send_item(ACT_APPEND, 5'd20, 31'h3_C3C3);
		send_item(ACT_APPEND, 5'd20, 31'h6_9696);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		write_capacity(bytes_out + 21'd3);
		send_item(ACT_APPEND, 5'd31, 31'h7FFF_FFFF);
		send_item(ACT_APPEND, 5'd31, 31'h7FFF_FFFF);
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
	endtask

	task automatic test_random_phases;
		logic [20:0] caps[5];
		caps[0] = CAP_MAX;
		caps[1] = mbp_pkg::BUF_BYTES_RST;
		caps[2] = '0;
		caps[3] = 21'd0;
		caps[4] = 21'($urandom_range(0, 1048576));
		for (int p = 0; p < 5; p++) begin
			if (p == 2)
				caps[2] = bytes_out + 21'($urandom_range(0, 40));
			write_capacity(caps[p]);
			for (int i = 0; i < 200; i++) begin
				send_random();
				if (i == 100 && p == 1)
					wait_idle();
			end
		end
	endtask

	// back-to-back beats, receiver always ready, running into the capacity limit; later gaps and stalls
	task automatic test_steady_stream;
		wait_idle();
		steady = 1'b1;
		write_capacity(bytes_out + 21'd24);
		for (int i = 0; i < 12; i++)
			send_item(ACT_APPEND, 5'd31, 31'($urandom));
		send_item(mbp_pkg::ACT_FLUSH, 5'd0, 31'd0);
		write_capacity(CAP_MAX);
		for (int i = 0; i < 40; i++)
			send_random();
		steady = 1'b0;
		for (int i = 0; i < 100; i++)
			send_random();
	endtask

	always @(negedge clk) begin
		if (steady || rx_mode == 0)
			m_axis_tready <= 1'b1;
		else begin
			case (rx_mode)
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ($urandom_range(0, 3) == 0);
				3: m_axis_tready <= (rx_cnt % 5 != 0);
				default: m_axis_tready <= (rx_cnt % 24 >= 16);
			endcase
		end
		rx_cnt++;
		rx_left--;
		if (rx_left <= 0) begin
			rx_mode = $urandom_range(0, 4);
			rx_left = $urandom_range(50, 300);
		end
	end

	always @(posedge clk) begin : result_check
		pack_res_t exp_r;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (due_results.size() == 0) begin
				errors++;
				$display("%0t: unexpected beat tdata=%h tuser=%0d", $time, m_axis_tdata,
					m_axis_tuser);
			end else begin
				exp_r = due_results.pop_front();
				if (m_axis_tdata[31:0] !== exp_r.word || m_axis_tdata[34:32] !== exp_r.nbytes
						|| m_axis_tdata[58:35] !== exp_r.total
						|| m_axis_tuser !== exp_r.status) begin
					errors++;
					if (errors <= 50)
						$display({"%0t: mismatch exp word=%h bytes=%0d status=%0d total=%0d,",
							" got word=%h bytes=%0d status=%0d total=%0d"},
							$time, exp_r.word, exp_r.nbytes, exp_r.status, exp_r.total,
							m_axis_tdata[31:0], m_axis_tdata[34:32], m_axis_tuser,
							m_axis_tdata[58:35]);
				end
			end
		end
	end

	initial begin
		acc_bits = '0;
		free_slots = 32;
		bytes_out = '0;
		capacity = mbp_pkg::BUF_BYTES_RST;
		repeat (7) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_capacity();
		test_random_phases();
		test_steady_stream();
		wait_idle();
		$display({"covered %0d beats: %0d full words, %0d flushes with data,",
			" %0d over-wide codes, %0d refusals"},
			n_beats, n_words, n_flushes, n_wide, n_full);
		$display("%0d capacity settings, stalls and gaps on both sides", n_cap_writes);
		if (errors == 0)
			$display("PASS msb_first_bit_packer");
		else
			$display("FAIL msb_first_bit_packer");
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/mbp_pkg.sv
hw/rtl/msb_first_bit_packer.sv
verif/tb.sv
